### src/rmf_pkg.sv
package rmf_pkg;

   // Pixel and frame geometry.
   localparam int PIXEL_BITS = 16;
   localparam int MAX_COLS   = 128;
   localparam int MAX_ROWS   = 128;

   // Field widths that the stream format fixes.
   localparam int POS_BITS    = 7;
   localparam int SIZE_BITS   = 8;
   localparam int REGION_BITS = 7;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 8;

   // Counter widths. The emit row counter may park at MAX_ROWS itself.
   localparam int COL_BITS  = $clog2(MAX_COLS);
   localparam int ROW_BITS  = $clog2(MAX_ROWS) + 1;
   localparam int SEEN_BITS = SIZE_BITS;
   localparam int CMP_BITS  = ((ROW_BITS > SIZE_BITS) ?
                               ((ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS) :
                               ((SIZE_BITS > COL_BITS) ? SIZE_BITS : COL_BITS)) + 1;

   // Stream widths, whole bytes.
   localparam int REQ_DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((PIXEL_BITS + 2 * POS_BITS + 7) / 8) * 8;

   // Arithmetic widths for the neighborhood sum and the mean.
   localparam int COLSUM_BITS = PIXEL_BITS + 2;
   localparam int SUM_BITS    = PIXEL_BITS + 4;
   localparam int MAG_BITS    = PIXEL_BITS + 3;
   localparam int RECIP_SHIFT = MAG_BITS + 4;
   localparam int RECIP_BITS  = RECIP_SHIFT - 1;
   localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;
   localparam int QUOT_BITS   = PROD_BITS - RECIP_SHIFT;

   // Rounded-up reciprocals; exact for every magnitude below 2**MAG_BITS.
   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
   localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'((RECIP_ONE + 64'd3) / 64'd4);
   localparam logic [RECIP_BITS-1:0] RECIP_6 = RECIP_BITS'((RECIP_ONE + 64'd5) / 64'd6);
   localparam logic [RECIP_BITS-1:0] RECIP_9 = RECIP_BITS'((RECIP_ONE + 64'd8) / 64'd9);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_ROWS       = 3'd0,
      CSR_FRAME_COLS       = 3'd1,
      CSR_REGION_FIRST_ROW = 3'd2,
      CSR_REGION_FIRST_COL = 3'd3,
      CSR_REGION_LAST_ROW  = 3'd4,
      CSR_REGION_LAST_COL  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_BY_4,
      DIV_BY_6,
      DIV_BY_9
   } div_type;

   // Everything known about an emitted pixel once its position is settled.
   typedef struct packed {
      logic                done;
      logic                in_region;
      logic                row_top;
      logic                row_bot;
      logic                col_left;
      logic                col_right;
      div_type             div;
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
   } emit_info_type;

   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                      input int maxv);
      logic [SIZE_BITS-1:0] res;
      res = v;
      if (v < SIZE_BITS'(2)) begin
         res = SIZE_BITS'(2);
      end else if (int'(v) > maxv) begin
         res = SIZE_BITS'(maxv);
      end
      return res;
   endfunction

   function automatic logic [RECIP_BITS-1:0] recip(input div_type d);
      logic [RECIP_BITS-1:0] res;
      case (d)
         DIV_BY_4: res = RECIP_4;
         DIV_BY_6: res = RECIP_6;
         DIV_BY_9: res = RECIP_9;
         default:  res = RECIP_9;
      endcase
      return res;
   endfunction

endpackage

### src/region_mean_filter_3x3.sv
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tdata: pixel_in; tuser: action (1 = drain item)
// rsp       out  rsp_tvalid/rsp_tready  tdata: pixel_out, out_row, out_col; tlast: frame_done
// csr       in   csr_we                 csr_index selects the register, csr_wdata its value
//
// One item is taken every clock cycle while the pipeline does not stall. A result is
// formed by the line memory read, the column sums, the total and the reciprocal multiply,
// each one stage; the reciprocal multiply stage ends in the output register.
// Reset is synchronous: counters, window and valid flags clear, registers take their
// defaults. The line memory is not cleared.
// The pipeline stalls only when the output register holds a result that is not taken
// and the last stage holds another one; items that emit nothing keep flowing.

module region_mean_filter_3x3 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rmf_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // pixel_in
   input  logic [0:0]                         req_tuser,  // action
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rmf_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // pixel_out, out_row, out_col, zeros
   output logic                               rsp_tlast,  // frame_done
   input  logic                               csr_we,
   input  logic [rmf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rmf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int P = rmf_pkg::PIXEL_BITS;

   // Configuration registers.
   logic [rmf_pkg::SIZE_BITS-1:0]   frame_rows_ff, frame_rows_in;
   logic [rmf_pkg::SIZE_BITS-1:0]   frame_cols_ff, frame_cols_in;
   logic [rmf_pkg::REGION_BITS-1:0] first_row_ff, first_row_in;
   logic [rmf_pkg::REGION_BITS-1:0] first_col_ff, first_col_in;
   logic [rmf_pkg::REGION_BITS-1:0] last_row_ff, last_row_in;
   logic [rmf_pkg::REGION_BITS-1:0] last_col_ff, last_col_in;

   // Stream position counters.
   logic [rmf_pkg::COL_BITS-1:0]  input_col_ff, input_col_in;
   logic [rmf_pkg::ROW_BITS-1:0]  emit_row_ff, emit_row_in;
   logic [rmf_pkg::COL_BITS-1:0]  emit_col_ff, emit_col_in;
   logic [rmf_pkg::SEEN_BITS-1:0] items_seen_ff, items_seen_in;

   // Line memory: each entry holds the two previous rows of one column, older row on top.
   logic [2*P-1:0] line_mem [rmf_pkg::MAX_COLS];
   logic [2*P-1:0] mem_rd_ff;
   logic [2*P-1:0] fwd_data_ff;
   logic           fwd_ff;
   logic [2*P-1:0] rd;
   logic [2*P-1:0] wr_data;
   logic           fwd;

   // Stage 1: item waiting for its line memory data.
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_emit_ff, s1_emit_in;
   rmf_pkg::emit_info_type        s1_info_ff, s1_info_in;
   logic signed [P-1:0]           s1_value_ff, s1_value_in;
   logic [rmf_pkg::COL_BITS-1:0]  s1_col_ff;

   // 3x3 window, row-major, newest column at index 2 of each row.
   logic signed [P-1:0] window_ff [9];
   logic signed [P-1:0] win_in [9];

   // Stage 2: masked column sums.
   logic                                  s2_emit_ff;
   rmf_pkg::emit_info_type                s2_info_ff;
   logic signed [rmf_pkg::COLSUM_BITS-1:0] s2_colsum_ff [3];
   logic signed [rmf_pkg::COLSUM_BITS-1:0] colsum_in [3];
   logic signed [P-1:0]                   s2_center_ff;

   // Stage 3: magnitude of the neighborhood sum.
   logic                              s3_emit_ff;
   rmf_pkg::emit_info_type            s3_info_ff;
   logic                              s3_neg_ff, s3_neg_in;
   logic [rmf_pkg::MAG_BITS-1:0]      s3_mag_ff, s3_mag_in;
   logic signed [P-1:0]               s3_center_ff;
   logic signed [rmf_pkg::SUM_BITS-1:0] total;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [P-1:0]                 rsp_pixel_ff, rsp_pixel_in;
   logic [rmf_pkg::POS_BITS-1:0] rsp_row_ff, rsp_row_in;
   logic [rmf_pkg::POS_BITS-1:0] rsp_col_ff, rsp_col_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [rmf_pkg::PROD_BITS-1:0] prod;
   logic [rmf_pkg::QUOT_BITS-1:0] quot;

   // Accept-side decode.
   logic                          en;
   logic                          accept;
   logic                          emit_now;
   logic [rmf_pkg::SIZE_BITS-1:0] rows, cols;
   logic [rmf_pkg::CMP_BITS-1:0]  r_c, c_c, rows_c, cols_c, in_col_c;

   //------------------------------------------------------------------
   // Configuration writes.
   //------------------------------------------------------------------
   always_comb begin
      frame_rows_in = frame_rows_ff;
      frame_cols_in = frame_cols_ff;
      first_row_in  = first_row_ff;
      first_col_in  = first_col_ff;
      last_row_in   = last_row_ff;
      last_col_in   = last_col_ff;
      if (csr_we) begin
         case (csr_index)
            rmf_pkg::CSR_FRAME_ROWS:       frame_rows_in = csr_wdata;
            rmf_pkg::CSR_FRAME_COLS:       frame_cols_in = csr_wdata;
            rmf_pkg::CSR_REGION_FIRST_ROW: first_row_in = csr_wdata[rmf_pkg::REGION_BITS-1:0];
            rmf_pkg::CSR_REGION_FIRST_COL: first_col_in = csr_wdata[rmf_pkg::REGION_BITS-1:0];
            rmf_pkg::CSR_REGION_LAST_ROW:  last_row_in = csr_wdata[rmf_pkg::REGION_BITS-1:0];
            rmf_pkg::CSR_REGION_LAST_COL:  last_col_in = csr_wdata[rmf_pkg::REGION_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff <= rmf_pkg::SIZE_BITS'(rmf_pkg::MAX_ROWS);
         frame_cols_ff <= rmf_pkg::SIZE_BITS'(rmf_pkg::MAX_COLS);
         first_row_ff  <= '0;
         first_col_ff  <= '0;
         last_row_ff   <= '1;
         last_col_ff   <= '1;
      end else begin
         frame_rows_ff <= frame_rows_in;
         frame_cols_ff <= frame_cols_in;
         first_row_ff  <= first_row_in;
         first_col_ff  <= first_col_in;
         last_row_ff   <= last_row_in;
         last_col_ff   <= last_col_in;
      end
   end

   //------------------------------------------------------------------
   // Flow control. The whole pipeline moves together unless a result in
   // the last stage has nowhere to go.
   //------------------------------------------------------------------
   assign en         = !(s3_emit_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   //------------------------------------------------------------------
   // Position bookkeeping at accept time. It depends only on counters and
   // configuration, so the emitted position, its edge flags and the frame
   // end are all settled before the pixel data arrives.
   //------------------------------------------------------------------
   assign rows     = rmf_pkg::clamp_size(frame_rows_ff, rmf_pkg::MAX_ROWS);
   assign cols     = rmf_pkg::clamp_size(frame_cols_ff, rmf_pkg::MAX_COLS);
   assign r_c      = rmf_pkg::CMP_BITS'(emit_row_ff);
   assign c_c      = rmf_pkg::CMP_BITS'(emit_col_ff);
   assign rows_c   = rmf_pkg::CMP_BITS'(rows);
   assign cols_c   = rmf_pkg::CMP_BITS'(cols);
   assign in_col_c = rmf_pkg::CMP_BITS'(input_col_ff);
   assign emit_now = rmf_pkg::CMP_BITS'(items_seen_ff) >= cols_c + rmf_pkg::CMP_BITS'(1);

   always_comb begin
      s1_info_in.row_top   = r_c != '0;
      s1_info_in.row_bot   = (r_c + rmf_pkg::CMP_BITS'(1)) < rows_c;
      s1_info_in.col_left  = c_c != '0;
      s1_info_in.col_right = (c_c + rmf_pkg::CMP_BITS'(1)) < cols_c;
      s1_info_in.done      = !s1_info_in.row_bot && !s1_info_in.col_right;
      s1_info_in.in_region = (r_c >= rmf_pkg::CMP_BITS'(first_row_ff)) &&
                             (r_c <= rmf_pkg::CMP_BITS'(last_row_ff)) &&
                             (c_c >= rmf_pkg::CMP_BITS'(first_col_ff)) &&
                             (c_c <= rmf_pkg::CMP_BITS'(last_col_ff));
      if (s1_info_in.row_top && s1_info_in.row_bot &&
          s1_info_in.col_left && s1_info_in.col_right) begin
         s1_info_in.div = rmf_pkg::DIV_BY_9;
      end else if ((s1_info_in.row_top && s1_info_in.row_bot) ||
                   (s1_info_in.col_left && s1_info_in.col_right)) begin
         s1_info_in.div = rmf_pkg::DIV_BY_6;
      end else begin
         s1_info_in.div = rmf_pkg::DIV_BY_4;
      end
      s1_info_in.row = rmf_pkg::POS_BITS'(emit_row_ff);
      s1_info_in.col = rmf_pkg::POS_BITS'(emit_col_ff);
   end

   // A drain item enters the line buffers as a zero pixel.
   assign s1_value_in = req_tuser[0] ? '0 : $signed(req_tdata[P-1:0]);
   assign s1_valid_in = accept;
   assign s1_emit_in  = accept && emit_now;

   always_comb begin
      input_col_in  = input_col_ff;
      emit_row_in   = emit_row_ff;
      emit_col_in   = emit_col_ff;
      items_seen_in = items_seen_ff;
      if (accept) begin
         if (emit_now && s1_info_in.done) begin
            // Last pixel of the frame: everything restarts with the next item.
            input_col_in  = '0;
            emit_row_in   = '0;
            emit_col_in   = '0;
            items_seen_in = '0;
         end else begin
            if (emit_now) begin
               if (!s1_info_in.col_right) begin
                  emit_col_in = '0;
                  if (emit_row_ff < rmf_pkg::ROW_BITS'(rmf_pkg::MAX_ROWS)) begin
                     emit_row_in = emit_row_ff + rmf_pkg::ROW_BITS'(1);
                  end
               end else begin
                  emit_col_in = emit_col_ff + rmf_pkg::COL_BITS'(1);
               end
            end
            if ((in_col_c + rmf_pkg::CMP_BITS'(1)) >= cols_c) begin
               input_col_in = '0;
            end else begin
               input_col_in = input_col_ff + rmf_pkg::COL_BITS'(1);
            end
            // Saturates well above the largest priming count.
            if (items_seen_ff != '1) begin
               items_seen_in = items_seen_ff + rmf_pkg::SEEN_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         input_col_ff  <= '0;
         emit_row_ff   <= '0;
         emit_col_ff   <= '0;
         items_seen_ff <= '0;
      end else begin
         input_col_ff  <= input_col_in;
         emit_row_ff   <= emit_row_in;
         emit_col_ff   <= emit_col_in;
         items_seen_ff <= items_seen_in;
      end
   end

   //------------------------------------------------------------------
   // Line memory: read at accept and written back from stage 1. The item
   // that follows a frame end reads the column just being written, so the
   // write data is captured beside the memory output and chosen instead.
   //------------------------------------------------------------------
   assign rd      = fwd_ff ? fwd_data_ff : mem_rd_ff;
   assign wr_data = {rd[P-1:0], s1_value_ff};
   assign fwd     = s1_valid_ff && (s1_col_ff == input_col_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         mem_rd_ff   <= line_mem[input_col_ff];
         fwd_ff      <= fwd;
         fwd_data_ff <= wr_data;
      end
      if (en && s1_valid_ff) begin
         line_mem[s1_col_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
         s1_emit_ff  <= s1_emit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_info_ff  <= s1_info_in;
         s1_value_ff <= s1_value_in;
         s1_col_ff   <= input_col_ff;
      end
   end

   //------------------------------------------------------------------
   // Window shift and masked column sums. Rows outside the frame drop out
   // of every column here; columns outside the frame drop out next stage.
   //------------------------------------------------------------------
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3+0] = window_ff[k*3+1];
         win_in[k*3+1] = window_ff[k*3+2];
      end
      win_in[2] = $signed(rd[2*P-1:P]);
      win_in[5] = $signed(rd[P-1:0]);
      win_in[8] = s1_value_ff;
      for (int b = 0; b < 3; b++) begin
         colsum_in[b] = (s1_info_ff.row_top ? rmf_pkg::COLSUM_BITS'(win_in[b]) : '0) +
                        rmf_pkg::COLSUM_BITS'(win_in[3+b]) +
                        (s1_info_ff.row_bot ? rmf_pkg::COLSUM_BITS'(win_in[6+b]) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else if (en && s1_valid_ff) begin
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= win_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else if (en) begin
         s2_emit_ff <= s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_info_ff   <= s1_info_ff;
         s2_center_ff <= win_in[4];
         for (int b = 0; b < 3; b++) begin
            s2_colsum_ff[b] <= colsum_in[b];
         end
      end
   end

   //------------------------------------------------------------------
   // Neighborhood total, split into sign and magnitude so the divide
   // truncates toward zero.
   //------------------------------------------------------------------
   always_comb begin
      total = (s2_info_ff.col_left ? rmf_pkg::SUM_BITS'(s2_colsum_ff[0]) : '0) +
              rmf_pkg::SUM_BITS'(s2_colsum_ff[1]) +
              (s2_info_ff.col_right ? rmf_pkg::SUM_BITS'(s2_colsum_ff[2]) : '0);
      s3_neg_in = total[rmf_pkg::SUM_BITS-1];
      s3_mag_in = s3_neg_in ? rmf_pkg::MAG_BITS'(-total) : rmf_pkg::MAG_BITS'(total);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_emit_ff <= 1'b0;
      end else if (en) begin
         s3_emit_ff <= s2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_info_ff   <= s2_info_ff;
         s3_neg_ff    <= s3_neg_in;
         s3_mag_ff    <= s3_mag_in;
         s3_center_ff <= s2_center_ff;
      end
   end

   //------------------------------------------------------------------
   // Mean by reciprocal multiply, then the output register.
   //------------------------------------------------------------------
   assign prod = rmf_pkg::PROD_BITS'(s3_mag_ff) *
                 rmf_pkg::PROD_BITS'(rmf_pkg::recip(s3_info_ff.div));
   assign quot = prod[rmf_pkg::PROD_BITS-1:rmf_pkg::RECIP_SHIFT];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      if (en && s3_emit_ff) begin
         rsp_valid_in = 1'b1;
         if (s3_info_ff.in_region) begin
            rsp_pixel_in = s3_neg_ff ? P'(-quot) : P'(quot);
         end else begin
            rsp_pixel_in = s3_center_ff;
         end
         rsp_row_in  = s3_info_ff.row;
         rsp_col_in  = s3_info_ff.col;
         rsp_last_in = s3_info_ff.done;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rmf_pkg::RSP_DATA_BITS'({rsp_col_ff, rsp_row_ff, rsp_pixel_ff});
   assign rsp_tlast  = rsp_last_ff;

   //------------------------------------------------------------------
   // Assertions.
   //------------------------------------------------------------------

   // The item that emits the last pixel restarts every position counter.
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && emit_now && s1_info_in.done) |=>
      (items_seen_ff == '0 && input_col_ff == '0 && emit_row_ff == '0 && emit_col_ff == '0))
      else $error("counters not cleared after frame end");

   // Reset leaves no item in flight and no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !s2_emit_ff && !s3_emit_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   // A result can only be scheduled for an item that is really present.
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      s1_emit_ff |-> s1_valid_ff)
      else $error("emission without an item in stage one");

   // Frames have at least two rows and columns, so every pixel has a vertical
   // and a horizontal neighbor, and the nine-way mean needs all four sides.
   a_edge_masks: assert property (@(posedge clock) disable iff (reset)
      s1_emit_ff |-> ((s1_info_ff.row_top || s1_info_ff.row_bot) &&
                      (s1_info_ff.col_left || s1_info_ff.col_right) &&
                      (s1_info_ff.div != rmf_pkg::DIV_BY_9 ||
                       (s1_info_ff.row_top && s1_info_ff.row_bot &&
                        s1_info_ff.col_left && s1_info_ff.col_right))))
      else $error("inconsistent edge masks for emitted pixel");

endmodule

### verif/tb.sv
module tb;

   // Positions of the result fields inside rsp_tdata, lowest bit first:
   // pixel_out, out_row, out_col, then zero padding up to a whole byte.
   localparam int ROW_LSB = rmf_pkg::PIXEL_BITS;
   localparam int COL_LSB = rmf_pkg::PIXEL_BITS + rmf_pkg::POS_BITS;
   localparam int PAD_LSB = rmf_pkg::PIXEL_BITS + 2 * rmf_pkg::POS_BITS;
   localparam int PAD_BITS = rmf_pkg::RSP_DATA_BITS - PAD_LSB;

   localparam logic [rmf_pkg::PIXEL_BITS-1:0] PIX_MIN =
      {1'b1, {(rmf_pkg::PIXEL_BITS-1){1'b0}}};
   localparam logic [rmf_pkg::PIXEL_BITS-1:0] PIX_MAX =
      {1'b0, {(rmf_pkg::PIXEL_BITS-1){1'b1}}};

   // Far above the slowest correct run: about 950 items, each with the longest
   // input gap and the longest output stall, plus register writes.
   localparam int CYCLE_LIMIT = 400000;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [rmf_pkg::REQ_DATA_BITS-1:0]   req_tdata;   // pixel_in
   logic [0:0]                          req_tuser;   // action (1 = drain item)
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [rmf_pkg::RSP_DATA_BITS-1:0]   rsp_tdata;   // pixel_out, out_row, out_col, zeros
   logic                                rsp_tlast;   // frame_done
   logic                                csr_we;
   logic [rmf_pkg::CSR_INDEX_BITS-1:0]  csr_index;
   logic [rmf_pkg::CSR_DATA_BITS-1:0]   csr_wdata;

   region_mean_filter_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // One emitted pixel as the filter should produce it.
   typedef struct {
      logic [rmf_pkg::PIXEL_BITS-1:0] value;
      logic [rmf_pkg::POS_BITS-1:0]   row;
      logic [rmf_pkg::POS_BITS-1:0]   col;
      logic                           done;
   } blurred_pixel_type;

   blurred_pixel_type pending_pixels[$];

   // Shadow copies of the registers, at their reset values.
   logic [rmf_pkg::SIZE_BITS-1:0]   rows_reg  = rmf_pkg::SIZE_BITS'(128);
   logic [rmf_pkg::SIZE_BITS-1:0]   cols_reg  = rmf_pkg::SIZE_BITS'(128);
   logic [rmf_pkg::REGION_BITS-1:0] first_row = '0;
   logic [rmf_pkg::REGION_BITS-1:0] first_col = '0;
   logic [rmf_pkg::REGION_BITS-1:0] last_row  = '1;
   logic [rmf_pkg::REGION_BITS-1:0] last_col  = '1;

   // Predicted filter state: two line buffers, the 3x3 neighborhood kept
   // row-major (index 4 is the pixel about to leave), and the stream counters.
   int older_line[rmf_pkg::MAX_COLS] = '{default: 0};
   int newer_line[rmf_pkg::MAX_COLS] = '{default: 0};
   int nbhd[9] = '{default: 0};
   int in_col = 0;
   int emit_row = 0;
   int emit_col = 0;
   int items_seen = 0;

   int  items_sent = 0;
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  req_calm = 1'b0;
   bit  rsp_calm = 1'b0;

   // Frame sizes are used clamped to [2, MAX].
   function automatic int size_in_use(input logic [rmf_pkg::SIZE_BITS-1:0] raw,
                                      input int limit);
      if (int'(raw) < 2) return 2;
      if (int'(raw) > limit) return limit;
      return int'(raw);
   endfunction

   // Cycles to hold off before the next item or result. Now and then the
   // side switches into a calm stretch with no holding off at all.
   function automatic int draw_pause(inout bit calm);
      if ($urandom_range(0, 31) == 0) calm = ~calm;
      return calm ? 0 : int'($urandom_range(0, 11));
   endfunction

   // Advance the predicted filter by one accepted item and queue the pixel
   // that it emits, if any.
   function automatic void advance_filter(input bit drain,
                                          input logic [rmf_pkg::PIXEL_BITS-1:0] pix);
      int rows, cols, value, top, mid, r, c, r0, r1, c0, c1, sum, count, mean;
      blurred_pixel_type px;
      rows = size_in_use(rows_reg, rmf_pkg::MAX_ROWS);
      cols = size_in_use(cols_reg, rmf_pkg::MAX_COLS);
      // A drain item enters the window as a zero pixel.
      value = drain ? 0 : int'($signed(pix));
      top = older_line[in_col];
      mid = newer_line[in_col];
      older_line[in_col] = mid;
      newer_line[in_col] = value;
      for (int k = 0; k < 3; k++) begin
         nbhd[k * 3]     = nbhd[k * 3 + 1];
         nbhd[k * 3 + 1] = nbhd[k * 3 + 2];
      end
      nbhd[2] = top;
      nbhd[5] = mid;
      nbhd[8] = value;

      // Output starts once the stream is one row plus one pixel ahead.
      if (items_seen >= cols + 1) begin
         r = emit_row;
         c = emit_col;
         mean = nbhd[4];
         if (r >= int'(first_row) && r <= int'(last_row) &&
             c >= int'(first_col) && c <= int'(last_col)) begin
            // Only in-frame neighbors count: 4 at a corner, 6 on an edge,
            // 9 inside. Integer division truncates toward zero.
            r0 = (r > 0) ? 0 : 1;
            r1 = (r + 1 < rows) ? 2 : 1;
            c0 = (c > 0) ? 0 : 1;
            c1 = (c + 1 < cols) ? 2 : 1;
            sum = 0;
            for (int a = r0; a <= r1; a++) begin
               for (int b = c0; b <= c1; b++) begin
                  sum += nbhd[a * 3 + b];
               end
            end
            count = (r1 - r0 + 1) * (c1 - c0 + 1);
            mean = sum / count;
         end
         px.value = rmf_pkg::PIXEL_BITS'(mean);
         px.row   = rmf_pkg::POS_BITS'(r);
         px.col   = rmf_pkg::POS_BITS'(c);
         px.done  = (r + 1 >= rows) && (c + 1 >= cols);
         pending_pixels.push_back(px);
         // The last pixel of the frame clears every counter.
         if (px.done) begin
            in_col = 0;
            emit_row = 0;
            emit_col = 0;
            items_seen = 0;
            return;
         end
         if (c + 1 >= cols) begin
            emit_col = 0;
            if (emit_row < rmf_pkg::MAX_ROWS) emit_row++;
         end else begin
            emit_col++;
         end
      end
      if (in_col + 1 >= cols) in_col = 0;
      else in_col++;
      items_seen++;
   endfunction

   // Write one register. The write lands at a rising edge while csr_we is high,
   // and the shadow copy follows it.
   task automatic write_reg(input rmf_pkg::csr_index_type idx,
                            input logic [rmf_pkg::CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         rmf_pkg::CSR_FRAME_ROWS:       rows_reg  = val;
         rmf_pkg::CSR_FRAME_COLS:       cols_reg  = val;
         rmf_pkg::CSR_REGION_FIRST_ROW: first_row = val[rmf_pkg::REGION_BITS-1:0];
         rmf_pkg::CSR_REGION_FIRST_COL: first_col = val[rmf_pkg::REGION_BITS-1:0];
         rmf_pkg::CSR_REGION_LAST_ROW:  last_row  = val[rmf_pkg::REGION_BITS-1:0];
         rmf_pkg::CSR_REGION_LAST_COL:  last_col  = val[rmf_pkg::REGION_BITS-1:0];
         default: ;
      endcase
   endtask

   // Offer one item after a random gap and hold it until the block takes it.
   // The valid stays high on return, so a following item with no gap goes out
   // on the very next cycle.
   task automatic send_item(input bit drain, input logic [rmf_pkg::PIXEL_BITS-1:0] pix);
      int gap;
      gap = draw_pause(req_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rmf_pkg::REQ_DATA_BITS'(pix);
      req_tuser  <= drain;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      advance_filter(drain, pix);
      items_sent++;
   endtask

   // Stop offering items and wait until every predicted pixel has come out,
   // then let the pipeline run on so that nothing is in flight.
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // One whole frame at the current sizes: rows*cols pixels with some drain
   // items mixed in, then cols+1 tail items that are mostly drains. Pixel items
   // in the tail are legal and act as drains.
   task automatic send_frame(input int drain_pct);
      int rows, cols;
      logic [rmf_pkg::PIXEL_BITS-1:0] pix;
      rows = size_in_use(rows_reg, rmf_pkg::MAX_ROWS);
      cols = size_in_use(cols_reg, rmf_pkg::MAX_COLS);
      for (int i = 0; i < rows * cols + cols + 1; i++) begin
         case ($urandom_range(0, 9))
            0:       pix = PIX_MIN;
            1:       pix = PIX_MAX;
            default: pix = rmf_pkg::PIXEL_BITS'($urandom);
         endcase
         if (i < rows * cols) send_item($urandom_range(0, 99) < drain_pct, pix);
         else send_item($urandom_range(0, 2) != 0, pix);
      end
   endtask

   // Choose one axis of the rectangle: inside the frame, anywhere at all,
   // empty (first past last), or the full reset span. Bit 7 of the write data
   // is random and must be ignored by the 7-bit registers.
   task automatic pick_region(input rmf_pkg::csr_index_type lo_reg, hi_reg,
                              input int span);
      int lo, hi;
      case ($urandom_range(0, 3))
         0: begin
            lo = $urandom_range(0, span - 1);
            hi = $urandom_range(lo, span - 1);
         end
         1: begin
            lo = $urandom_range(0, 127);
            hi = $urandom_range(0, 127);
         end
         2: begin
            lo = $urandom_range(1, span);
            hi = $urandom_range(0, lo - 1);
         end
         default: begin
            lo = 0;
            hi = 127;
         end
      endcase
      write_reg(lo_reg, {1'($urandom_range(0, 1)), 7'(lo)});
      write_reg(hi_reg, {1'($urandom_range(0, 1)), 7'(hi)});
   endtask

   // A 3x3 frame under the reset rectangle, so every pixel is blurred: the
   // corners divide by 4, the edges by 6 and the center by 9. The values sit
   // at both ends of the range and near zero, so negative sums truncate.
   task automatic test_full_region_after_reset();
      logic [rmf_pkg::PIXEL_BITS-1:0] pixels[9] = '{PIX_MAX, PIX_MAX, PIX_MIN,
                                                    PIX_MIN, PIX_MIN, PIX_MIN,
                                                    PIX_MIN, '1,
                                                    rmf_pkg::PIXEL_BITS'(1)};
      write_reg(rmf_pkg::CSR_FRAME_ROWS, rmf_pkg::SIZE_BITS'(3));
      write_reg(rmf_pkg::CSR_FRAME_COLS, rmf_pkg::SIZE_BITS'(3));
      foreach (pixels[i]) send_item(1'b0, pixels[i]);
      // Drain items carry junk in the pixel field; it must not matter.
      repeat (4) send_item(1'b1, rmf_pkg::PIXEL_BITS'($urandom));
      settle_block();
   endtask

   // A 2x3 frame where only the bottom row from column 1 on is blurred, so
   // the rest passes through. A drain item stands in for one pixel and must
   // act as a zero, and pixel items after the last pixel act as drains.
   task automatic test_drains_and_partial_region();
      write_reg(rmf_pkg::CSR_FRAME_ROWS, rmf_pkg::SIZE_BITS'(2));
      write_reg(rmf_pkg::CSR_FRAME_COLS, rmf_pkg::SIZE_BITS'(3));
      write_reg(rmf_pkg::CSR_REGION_FIRST_ROW, 8'd1);
      write_reg(rmf_pkg::CSR_REGION_FIRST_COL, 8'd1);
      write_reg(rmf_pkg::CSR_REGION_LAST_ROW, 8'd1);
      write_reg(rmf_pkg::CSR_REGION_LAST_COL, 8'd2);
      send_item(1'b0, 16'h0100);
      send_item(1'b0, 16'hFF00);
      send_item(1'b1, PIX_MAX);
      send_item(1'b0, PIX_MIN);
      send_item(1'b0, 16'h0003);
      send_item(1'b0, 16'hFFFD);
      send_item(1'b0, PIX_MAX);
      send_item(1'b1, 16'h1234);
      send_item(1'b0, PIX_MIN);
      send_item(1'b0, 16'h55AA);
      settle_block();
   endtask

   // The largest sizes, reached through clamping: 255 rows become 128 and
   // 0 columns become 2; then 1 row becomes 2 and 200 columns become 128.
   task automatic test_size_extremes();
      write_reg(rmf_pkg::CSR_FRAME_ROWS, 8'hFF);
      write_reg(rmf_pkg::CSR_FRAME_COLS, 8'h00);
      write_reg(rmf_pkg::CSR_REGION_FIRST_ROW, 8'h00);
      write_reg(rmf_pkg::CSR_REGION_FIRST_COL, 8'h00);
      write_reg(rmf_pkg::CSR_REGION_LAST_ROW, 8'h7F);
      write_reg(rmf_pkg::CSR_REGION_LAST_COL, 8'hFF);
      send_frame(5);
      settle_block();
      write_reg(rmf_pkg::CSR_FRAME_ROWS, 8'h01);
      write_reg(rmf_pkg::CSR_FRAME_COLS, 8'd200);
      write_reg(rmf_pkg::CSR_REGION_FIRST_ROW, 8'h80);
      write_reg(rmf_pkg::CSR_REGION_FIRST_COL, 8'd5);
      write_reg(rmf_pkg::CSR_REGION_LAST_ROW, 8'd1);
      write_reg(rmf_pkg::CSR_REGION_LAST_COL, 8'd120);
      send_frame(5);
      settle_block();
   endtask

   // Many small frames. Most of the time the block is settled and given new
   // sizes and a new rectangle; otherwise the next frame follows the last one
   // with no break, right across the frame boundary.
   task automatic test_random_frames();
      int start_count, rows, cols;
      start_count = items_sent;
      while (items_sent - start_count < 170) begin
         if (items_sent == start_count || $urandom_range(0, 2) != 0) begin
            settle_block();
            rows = $urandom_range(2, 8);
            cols = $urandom_range(2, 10);
            // Now and then a size below the minimum, which clamps to 2.
            if ($urandom_range(0, 9) == 0) rows = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0) cols = $urandom_range(0, 1);
            write_reg(rmf_pkg::CSR_FRAME_ROWS, rmf_pkg::SIZE_BITS'(rows));
            write_reg(rmf_pkg::CSR_FRAME_COLS, rmf_pkg::SIZE_BITS'(cols));
            pick_region(rmf_pkg::CSR_REGION_FIRST_ROW, rmf_pkg::CSR_REGION_LAST_ROW,
                        size_in_use(rows_reg, rmf_pkg::MAX_ROWS));
            pick_region(rmf_pkg::CSR_REGION_FIRST_COL, rmf_pkg::CSR_REGION_LAST_COL,
                        size_in_use(cols_reg, rmf_pkg::MAX_COLS));
         end
         send_frame($urandom_range(0, 1) ? 0 : 10);
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
   endtask

   // The result side: hold off each result for a random number of cycles,
   // then keep ready high until the block offers one.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         stall = draw_pause(rsp_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid === 1'b1 && reset === 1'b0)) @(posedge clock);
         @(negedge clock);
      end
   end

   // Every pixel taken from the block is compared with the oldest prediction.
   always @(posedge clock) begin
      blurred_pixel_type want;
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected item", '0, rsp_tdata);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[rmf_pkg::PIXEL_BITS-1:0] !== want.value)
               report_mismatch("pixel_out", want.value, rsp_tdata[rmf_pkg::PIXEL_BITS-1:0]);
            if (rsp_tdata[ROW_LSB +: rmf_pkg::POS_BITS] !== want.row)
               report_mismatch("out_row", want.row, rsp_tdata[ROW_LSB +: rmf_pkg::POS_BITS]);
            if (rsp_tdata[COL_LSB +: rmf_pkg::POS_BITS] !== want.col)
               report_mismatch("out_col", want.col, rsp_tdata[COL_LSB +: rmf_pkg::POS_BITS]);
            if (rsp_tdata[PAD_LSB +: PAD_BITS] !== '0)
               report_mismatch("tdata padding", '0, rsp_tdata[PAD_LSB +: PAD_BITS]);
            if (rsp_tlast !== want.done)
               report_mismatch("frame_done", want.done, rsp_tlast);
         end
      end
   end

   // A hung handshake or a pixel that never comes ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = rmf_pkg::CSR_FRAME_ROWS;
      csr_wdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_full_region_after_reset();
      test_drains_and_partial_region();
      test_size_extremes();
      test_random_frames();
      settle_block();

      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
